@@ sv/event_trace_ring_recorder_core_macros.svh @@
// Assertion macros shared by the trace recorder RTL.
`ifndef EVENT_TRACE_RING_RECORDER_CORE_MACROS_SVH
`define EVENT_TRACE_RING_RECORDER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define ETR_ASSERT_IMPL(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define ETR_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ sv/etr_pkg.sv @@
// Types and constants of the event trace ring recorder.
`default_nettype none

package etr_pkg;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_SESSION = 2'd1;
  localparam logic [1:0] OP_REWIND  = 2'd2;
  localparam logic [1:0] OP_PULL    = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] timestamp_ms;
    logic [7:0]  event_code;
    logic [7:0]  stage_tag;
    logic [15:0] arg_value;
  } etr_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] delta_ms;
    logic [7:0]  out_event;
    logic [7:0]  out_stage;
    logic [15:0] out_arg;
    logic [7:0]  shown_count;
    logic [15:0] total_count;
  } etr_out_t;

  // One stored trail entry.
  typedef struct packed {
    logic [31:0] ts_ms;
    logic [7:0]  ev;
    logic [7:0]  stage;
    logic [15:0] arg;
  } etr_entry_t;

  // What the control side knows about a pull when it is accepted.
  typedef struct packed {
    logic        found;
    logic [31:0] newest_ms;
    logic [7:0]  shown;
    logic [15:0] total;
  } etr_pull_meta_t;

endpackage

`default_nettype wire

@@ sv/etr_trail_ram.sv @@
// Trail memory: one write port, one registered read port.
`default_nettype none

module etr_trail_ram #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  etr_pkg::etr_entry_t       wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output etr_pkg::etr_entry_t       rd_data
);
  import etr_pkg::*;

  etr_entry_t mem [DEPTH];
  etr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/etr_ctrl.sv @@
// Bank, head, count and cursor bookkeeping; memory address generation.
`default_nettype none

module etr_ctrl #(
  parameter int TRAIL_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  etr_pkg::etr_in_t                    item,
  output logic                                wr_en,
  output logic [$clog2(2*TRAIL_DEPTH)-1:0]    wr_addr,
  output etr_pkg::etr_entry_t                 wr_data,
  output logic                                rd_en,
  output logic [$clog2(2*TRAIL_DEPTH)-1:0]    rd_addr,
  output etr_pkg::etr_pull_meta_t             meta
);
  import etr_pkg::*;

  localparam int AW    = $clog2(TRAIL_DEPTH);
  localparam int CW    = $clog2(TRAIL_DEPTH + 1);
  localparam int SW    = CW + 2;
  localparam int MAW   = $clog2(2 * TRAIL_DEPTH);

  logic [AW-1:0] head0_r, head0_nxt, head1_r, head1_nxt;
  logic [15:0]   cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [31:0]   newest0_r, newest0_nxt, newest1_r, newest1_nxt;
  logic          live_bank_r, live_bank_nxt;
  logic          live_valid_r, live_valid_nxt;
  logic          saved_valid_r, saved_valid_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  logic          lb, sb, nb;
  logic [AW-1:0] head_live, head_sav, h_eff, h_inc, idx;
  logic [15:0]   cnt_live, cnt_sav, c_eff, c_inc, total, shown_w;
  logic [CW-1:0] shown_c;
  logic [SW-1:0] idx_sum;
  logic          hit;

  always_comb begin
    lb        = live_bank_r;
    sb        = ~live_bank_r;
    head_live = lb ? head1_r : head0_r;
    cnt_live  = lb ? cnt1_r  : cnt0_r;
    head_sav  = sb ? head1_r : head0_r;
    cnt_sav   = sb ? cnt1_r  : cnt0_r;

    // A push onto a dead live trail starts it afresh.
    h_eff = live_valid_r ? head_live : '0;
    c_eff = live_valid_r ? cnt_live  : '0;
    h_inc = (h_eff == AW'(TRAIL_DEPTH - 1)) ? '0 : h_eff + 1'b1;
    c_inc = (c_eff == COUNT_MAX) ? c_eff : c_eff + 16'd1;

    total   = saved_valid_r ? cnt_sav : '0;
    shown_w = (total < 16'(TRAIL_DEPTH)) ? total : 16'(TRAIL_DEPTH);
    shown_c = shown_w[CW-1:0];
    hit     = cursor_r < shown_c;

    // Oldest-first index: head - shown + cursor, folded into the ring.
    idx_sum = SW'(head_sav) + SW'(TRAIL_DEPTH) + SW'(cursor_r) - SW'(shown_c);
    idx     = (idx_sum >= SW'(TRAIL_DEPTH)) ? AW'(idx_sum - SW'(TRAIL_DEPTH))
                                             : AW'(idx_sum);
    nb      = live_valid_r ? sb : lb;
  end

  always_comb begin
    head0_nxt       = head0_r;
    head1_nxt       = head1_r;
    cnt0_nxt        = cnt0_r;
    cnt1_nxt        = cnt1_r;
    newest0_nxt     = newest0_r;
    newest1_nxt     = newest1_r;
    live_bank_nxt   = live_bank_r;
    live_valid_nxt  = live_valid_r;
    saved_valid_nxt = saved_valid_r;
    cursor_nxt      = cursor_r;
    if (fire) begin
      unique case (item.operation)
        OP_PUSH: begin
          live_valid_nxt = 1'b1;
          if (lb) begin
            head1_nxt   = h_inc;
            cnt1_nxt    = c_inc;
            newest1_nxt = item.timestamp_ms;
          end else begin
            head0_nxt   = h_inc;
            cnt0_nxt    = c_inc;
            newest0_nxt = item.timestamp_ms;
          end
        end
        OP_SESSION: begin
          if (live_valid_r) begin
            live_bank_nxt   = sb;
            saved_valid_nxt = 1'b1;
          end
          live_valid_nxt = 1'b1;
          if (nb) begin
            head1_nxt = '0;
            cnt1_nxt  = '0;
          end else begin
            head0_nxt = '0;
            cnt0_nxt  = '0;
          end
        end
        OP_REWIND: begin
          cursor_nxt = '0;
        end
        OP_PULL: begin
          if (hit) begin
            cursor_nxt = cursor_r + 1'b1;
          end
        end
        default: begin
          cursor_nxt = cursor_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head0_r       <= '0;
      head1_r       <= '0;
      cnt0_r        <= '0;
      cnt1_r        <= '0;
      live_bank_r   <= 1'b0;
      live_valid_r  <= 1'b0;
      saved_valid_r <= 1'b0;
      cursor_r      <= '0;
    end else begin
      head0_r       <= head0_nxt;
      head1_r       <= head1_nxt;
      cnt0_r        <= cnt0_nxt;
      cnt1_r        <= cnt1_nxt;
      live_bank_r   <= live_bank_nxt;
      live_valid_r  <= live_valid_nxt;
      saved_valid_r <= saved_valid_nxt;
      cursor_r      <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest0_r <= newest0_nxt;
    newest1_r <= newest1_nxt;
  end

  assign wr_en         = fire && (item.operation == OP_PUSH);
  assign wr_addr       = lb ? MAW'(TRAIL_DEPTH) + MAW'(h_eff) : MAW'(h_eff);
  assign wr_data.ts_ms = item.timestamp_ms;
  assign wr_data.ev    = item.event_code;
  assign wr_data.stage = item.stage_tag;
  assign wr_data.arg   = item.arg_value;

  assign rd_en   = fire && (item.operation == OP_PULL);
  assign rd_addr = sb ? MAW'(TRAIL_DEPTH) + MAW'(idx) : MAW'(idx);

  assign meta.found     = hit;
  assign meta.newest_ms = sb ? newest1_r : newest0_r;
  assign meta.shown     = shown_w[7:0];
  assign meta.total     = total;

endmodule

`default_nettype wire

@@ sv/event_trace_ring_recorder_core.sv @@
// A pull's result goes through stage one (the memory read), then the output register.
// Throughput: one item per cycle while not stalled, set by the single read port of
//   the trail RAM and its register stage; pushes, sessions, rewinds give no result.
// Reset: rst_n (synchronous) clears banks, heads, counts, cursor and the pipeline.
// The trail memory is not cleared; no clearing pass, the block is ready at once.
`default_nettype none

`include "event_trace_ring_recorder_core_macros.svh"

module event_trace_ring_recorder_core #(
  parameter int TRAIL_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  etr_pkg::etr_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output etr_pkg::etr_out_t out_item
);
  import etr_pkg::*;

  localparam int MAW = $clog2(2 * TRAIL_DEPTH);

  logic           in_fire;
  logic           out_free;
  logic           s1_adv;

  logic           wr_en, rd_en;
  logic [MAW-1:0] wr_addr, rd_addr;
  etr_entry_t     wr_data, rd_data;
  etr_pull_meta_t meta;

  // Stage one: pull bookkeeping waits beside the memory read.
  logic           s1_valid_r, s1_valid_nxt;
  etr_pull_meta_t s1_meta_r;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  etr_out_t       out_item_r, out_item_nxt;

  // The output register parts the two sides: take a new item whenever
  // stage one is empty or about to move on.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  etr_ctrl #(
    .TRAIL_DEPTH (TRAIL_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .item    (in_item),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .meta    (meta)
  );

  // The read data holds while stage one holds: a read is only issued when
  // a pull is accepted, which needs stage one free.
  etr_trail_ram #(
    .DEPTH (2 * TRAIL_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end

    // Age against the newest entry; a miss reports zeros but keeps the counts.
    out_item_nxt.found       = s1_meta_r.found;
    out_item_nxt.delta_ms    = s1_meta_r.found ? s1_meta_r.newest_ms - rd_data.ts_ms : '0;
    out_item_nxt.out_event   = s1_meta_r.found ? rd_data.ev    : '0;
    out_item_nxt.out_stage   = s1_meta_r.found ? rd_data.stage : '0;
    out_item_nxt.out_arg     = s1_meta_r.found ? rd_data.arg   : '0;
    out_item_nxt.shown_count = s1_meta_r.shown;
    out_item_nxt.total_count = s1_meta_r.total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ETR_ASSERT_NEXT(a_pull_enters_s1, in_fire && in_item.operation == OP_PULL, s1_valid_r, "accepted pull did not reach stage one")
  `ETR_ASSERT_NEXT(a_s1_holds, s1_valid_r && !out_free, s1_valid_r && $stable(s1_meta_r), "stage one lost its item while blocked")
  `ETR_ASSERT_IMPL(a_miss_zero, out_valid_r && !out_item_r.found, out_item_r.delta_ms == '0 && out_item_r.out_arg == '0, "miss result carries entry data")
  `ETR_ASSERT_IMPL(a_found_total, out_valid_r && out_item_r.found, out_item_r.total_count != '0, "hit reported on an empty trail")

endmodule

`default_nettype wire

@@ sim/tb_event_trace_ring_recorder_core.sv @@
// Self-checking testbench of the event trace ring recorder: directed table, random trails, scoreboard.
`default_nettype none

module tb_event_trace_ring_recorder_core;
  import etr_pkg::*;

  localparam int DEPTH = 128;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off to fill the pipeline
  localparam int ITEMS_PER_PHASE = 350;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  etr_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  etr_out_t out_item;

  event_trace_ring_recorder_core #(
    .TRAIL_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Safety net: a correct run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("FAIL event_trace_ring_recorder_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the recorder state. Bank b's slot i lives at b*DEPTH + i.
  // ---------------------------------------------------------------------------
  etr_entry_t  ring_store [2*DEPTH];
  int unsigned bank_wr_ptr [2];
  int unsigned bank_pushes [2];
  int unsigned active_bank;
  bit          active_ok;
  bit          archive_ok;
  int unsigned pull_pos;

  etr_out_t    pull_results_due [$];   // pull results still to come, oldest first
  int          mismatches;
  int          items_sent;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_req;               // bumped by the stimulus to ask for a hold-off
  int          hold_done;
  int          hold_left;

  // Work out what one accepted item does to the recorder, and the pull result if any.
  function automatic void recorder_predict(input etr_in_t it, output bit gives,
                                           output etr_out_t res);
    int unsigned arch;
    int unsigned total;
    int unsigned shown;
    int unsigned idx;
    int unsigned newest;
    gives = 1'b0;
    res   = '0;
    case (it.operation)
      OP_PUSH: begin
        // A push onto a dead live trail brings it to life, empty, first.
        if (!active_ok) begin
          active_ok = 1'b1;
          bank_wr_ptr[active_bank] = 0;
          bank_pushes[active_bank] = 0;
        end
        ring_store[active_bank*DEPTH + bank_wr_ptr[active_bank]] =
          {it.timestamp_ms, it.event_code, it.stage_tag, it.arg_value};
        bank_wr_ptr[active_bank] = (bank_wr_ptr[active_bank] + 1) % DEPTH;
        if (bank_pushes[active_bank] < COUNT_MAX) bank_pushes[active_bank]++;
      end
      OP_SESSION: begin
        // Swap only when there is a live trail to keep; the cursor stays put.
        if (active_ok) begin
          active_bank = active_bank ^ 1;
          archive_ok  = 1'b1;
        end
        active_ok = 1'b1;
        bank_wr_ptr[active_bank] = 0;
        bank_pushes[active_bank] = 0;
      end
      OP_REWIND: begin
        pull_pos = 0;
      end
      default: begin
        arch  = active_bank ^ 1;
        total = archive_ok ? bank_pushes[arch] : 0;
        shown = (total < DEPTH) ? total : DEPTH;
        gives = 1'b1;
        if (pull_pos < shown) begin
          // Oldest shown entry sits shown slots behind the head; the newest just behind.
          idx    = (bank_wr_ptr[arch] + DEPTH - shown + pull_pos) % DEPTH;
          newest = (bank_wr_ptr[arch] + DEPTH - 1) % DEPTH;
          res.found     = 1'b1;
          res.delta_ms  = ring_store[arch*DEPTH + newest].ts_ms
                          - ring_store[arch*DEPTH + idx].ts_ms;
          res.out_event = ring_store[arch*DEPTH + idx].ev;
          res.out_stage = ring_store[arch*DEPTH + idx].stage;
          res.out_arg   = ring_store[arch*DEPTH + idx].arg;
          pull_pos++;
        end
        res.shown_count = 8'(shown);
        res.total_count = 16'(total);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %0s: got %0h, want %0h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest pull still due.
  task automatic check_pull_result(input etr_out_t got);
    etr_out_t want;
    if (pull_results_due.size() == 0) begin
      report_mismatch("result with no pull due", 32'(got.total_count), '0);
      return;
    end
    want = pull_results_due.pop_front();
    if (got.found !== want.found)             report_mismatch("found", 32'(got.found),
                                                              32'(want.found));
    if (got.delta_ms !== want.delta_ms)       report_mismatch("delta_ms", got.delta_ms,
                                                              want.delta_ms);
    if (got.out_event !== want.out_event)     report_mismatch("out_event", 32'(got.out_event),
                                                              32'(want.out_event));
    if (got.out_stage !== want.out_stage)     report_mismatch("out_stage", 32'(got.out_stage),
                                                              32'(want.out_stage));
    if (got.out_arg !== want.out_arg)         report_mismatch("out_arg", 32'(got.out_arg),
                                                              32'(want.out_arg));
    if (got.shown_count !== want.shown_count) report_mismatch("shown_count",
                                                              32'(got.shown_count),
                                                              32'(want.shown_count));
    if (got.total_count !== want.total_count) report_mismatch("total_count",
                                                              32'(got.total_count),
                                                              32'(want.total_count));
  endtask

  // Offer one item, hold it until accepted, then record what it should cause.
  // A typed expectation, where given, replaces the predicted pull result.
  task automatic send_item(input etr_in_t it, input bit typed, input etr_out_t want);
    bit       gives;
    etr_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    recorder_predict(it, gives, res);
    if (gives) pull_results_due.push_back(typed ? want : res);
  endtask

  // Send one item of the given kind with random content in every field.
  task automatic issue(input logic [1:0] op);
    etr_in_t it;
    it.operation    = op;
    it.timestamp_ms = $urandom;
    it.event_code   = 8'($urandom);
    it.stage_tag    = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom);
    it.arg_value    = 16'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // Mostly a whole session: fill a trail, save it and read it back;
  // otherwise a short burst of random operations.
  task automatic run_trail_sequence();
    int n_push;
    int n_pull;
    if ($urandom_range(99) < 80) begin
      n_push = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(260, 100);
      issue(OP_SESSION);
      repeat (n_push) issue(OP_PUSH);
      issue(OP_SESSION);
      // Leave the rewind out now and then: the cursor must survive the session.
      if ($urandom_range(3) != 0) issue(OP_REWIND);
      n_pull = ((n_push < DEPTH) ? n_push : DEPTH) + $urandom_range(2);
      repeat (n_pull) begin
        issue(OP_PULL);
        case ($urandom_range(39))
          0:       issue(OP_REWIND);
          1, 2:    issue(OP_PUSH);     // live pushes must not disturb the saved trail
          default: ;
        endcase
      end
    end else begin
      repeat ($urandom_range(10, 1)) issue(2'($urandom_range(3)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result, then pick out_ready for the next cycle.
  // A pending hold-off request holds out_ready low until hold_left runs out.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_pull_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows whose result is obvious carry it (typed = 1): every one of
  // them is a pull that finds nothing, so only the two counts need stating.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ts;
    logic [7:0]  ev;
    logic [7:0]  st;
    logic [15:0] arg;
    logic        typed;
    logic [7:0]  shown;
    logic [15:0] total;
  } stim_row_t;

  localparam int NUM_ROWS = 25;

  stim_row_t stim_rows [NUM_ROWS] = '{
    // pull straight after reset: nothing saved
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b1, 8'd0, 16'd0},
    // new session with no live trail: no swap, still nothing saved
    '{OP_SESSION, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 8'd0, 16'd0},
    // field extremes into the live trail
    '{OP_PUSH,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PUSH,    32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 8'd0, 16'd0},
    '{OP_PUSH,    32'h0000_0005, 8'h5A, 8'hFF, 16'h1234, 1'b0, 8'd0, 16'd0},
    '{OP_PUSH,    32'h8000_0000, 8'h80, 8'h00, 16'h8000, 1'b0, 8'd0, 16'd0},
    // live trail alone is not readable
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b1, 8'd0, 16'd0},
    // save the four entries and read them oldest first
    '{OP_SESSION, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    // exhausted: nothing found, counts still shown
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b1, 8'd4, 16'd4},
    '{OP_REWIND,  32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PUSH,    32'h0000_0007, 8'h01, 8'h02, 16'h0003, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    // session leaves the cursor at 2, past the one saved entry
    '{OP_SESSION, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b1, 8'd1, 16'd1},
    '{OP_REWIND,  32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    // saving an empty live trail gives an empty saved trail
    '{OP_SESSION, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0},
    '{OP_PULL,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b1, 8'd0, 16'd0},
    '{OP_REWIND,  32'h0000_0000, 8'h00, 8'h00, 16'h0000, 1'b0, 8'd0, 16'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    int        target;
    active_bank = 0;
    active_ok   = 1'b0;
    archive_ok  = 1'b0;
    pull_pos    = 0;
    bank_wr_ptr = '{0, 0};
    bank_pushes = '{0, 0};
    mismatches  = 0;
    items_sent  = 0;
    hold_req    = 0;
    hold_done   = 0;
    hold_left   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 87;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_item({row.op, row.ts, row.ev, row.st, row.arg}, row.typed,
                {1'b0, 32'd0, 8'd0, 8'd0, 16'd0, row.shown, row.total});
    end

    // Three idling phases: sender light and receiver heavy, then swapped, then none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 2) begin
        // Hold the receiver off while a full trail is pulled: the block backs up
        // and must stall its input without losing or reordering anything.
        issue(OP_SESSION);
        repeat (200) issue(OP_PUSH);
        issue(OP_SESSION);
        issue(OP_REWIND);
        hold_req++;
        repeat (DEPTH + 2) issue(OP_PULL);
      end

      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) run_trail_sequence();
    end

    in_valid <= 1'b0;

    // Drain, then keep watching for any stray result to show up.
    while (pull_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pull_results_due.size() == 0) begin
      $display("PASS event_trace_ring_recorder_core");
    end else begin
      $display("FAIL event_trace_ring_recorder_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
